/* rtl/core/mgcpcc_pkg.sv */
// Shared types and constants for the MGCP command classifier.
package mgcpcc_pkg;

  localparam int unsigned VERB_COUNT = 9;
  localparam int unsigned VERB_LEN   = 5;
  localparam int unsigned MARKER_LEN = 5;

  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_AT    = 8'h40;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // Offset of the final byte must be at least this for a command.
  localparam int unsigned MIN_LAST_POS = 7;

  // Command verbs, each five characters including the trailing space.
  localparam logic [7:0] VERB_TABLE [VERB_COUNT][VERB_LEN] = '{
    '{"A", "U", "E", "P", " "},
    '{"A", "U", "C", "X", " "},
    '{"C", "R", "C", "X", " "},
    '{"D", "L", "C", "X", " "},
    '{"E", "P", "C", "F", " "},
    '{"M", "D", "C", "X", " "},
    '{"N", "T", "F", "Y", " "},
    '{"R", "Q", "N", "T", " "},
    '{"R", "S", "I", "P", " "}
  };

  // Protocol marker that must follow the endpoint.
  localparam logic [7:0] MARKER_TEXT [MARKER_LEN] = '{"M", "G", "C", "P", " "};

  // One classification result word.
  typedef struct packed {
    logic        is_mgcp;
    logic [15:0] host_offset;
    logic [15:0] host_length;
  } result_t;

endpackage

/* rtl/core/mgcpcc_parser.sv */
// Input register and per-byte parser state for the MGCP command classifier.
module mgcpcc_parser #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_payload_byte,
  input  logic                in_end_of_payload,
  output logic                in_stall,
  input  logic                res_stall,
  output logic                res_valid,
  output mgcpcc_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_VERB,
    PH_TXID,
    PH_ENDPOINT,
    PH_MARKER,
    PH_TAIL,
    PH_FAIL
  } phase_t;

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] POS_MIN_LAST =
    POSITION_BITS'(mgcpcc_pkg::MIN_LAST_POS);
  localparam logic [POSITION_BITS-1:0] POS_VERB_END =
    POSITION_BITS'(mgcpcc_pkg::VERB_LEN - 1);
  localparam logic [2:0] MARKER_LAST = 3'(mgcpcc_pkg::MARKER_LEN - 1);

  // Input register
  logic                     s1_valid_r, s1_valid_nxt;
  logic [7:0]               s1_byte_r;
  logic                     s1_last_r;

  // Parser state
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  phase_t                   phase_r, phase_nxt;
  logic [8:0]               cand_r, cand_nxt;
  logic [POSITION_BITS-1:0] ep_start_r, ep_start_nxt;
  logic [POSITION_BITS-1:0] at_pos_r, at_pos_nxt;
  logic                     at_seen_r, at_seen_nxt;
  logic [2:0]               mcnt_r, mcnt_nxt;
  logic [POSITION_BITS-1:0] ep_end_r, ep_end_nxt;

  logic                     hold;
  logic                     fire;
  logic                     hit;
  logic [POSITION_BITS-1:0] off;
  logic [POSITION_BITS-1:0] len;

  // Hold a final word in the input register while the result slot is blocked
  assign hold     = s1_valid_r && s1_last_r && res_stall;
  assign in_stall = hold;
  assign fire     = s1_valid_r && !hold;

  assign s1_valid_nxt = hold ? s1_valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      s1_byte_r <= in_payload_byte;
      s1_last_r <= in_end_of_payload;
    end
  end

  // Advance the parser by one byte
  always_comb begin
    pos_nxt      = pos_r;
    phase_nxt    = phase_r;
    cand_nxt     = cand_r;
    ep_start_nxt = ep_start_r;
    at_pos_nxt   = at_pos_r;
    at_seen_nxt  = at_seen_r;
    mcnt_nxt     = mcnt_r;
    ep_end_nxt   = ep_end_r;
    if (pos_r == POS_MAX) begin
      phase_nxt = PH_FAIL;
    end else begin
      pos_nxt = pos_r + 1'b1;
      case (phase_r)
        PH_VERB: begin
          for (int k = 0; k < mgcpcc_pkg::VERB_COUNT; k++) begin
            if (mgcpcc_pkg::VERB_TABLE[k][pos_r[2:0]] != s1_byte_r) begin
              cand_nxt[k] = 1'b0;
            end
          end
          if (cand_nxt == '0) begin
            phase_nxt = PH_FAIL;
          end else if (pos_r >= POS_VERB_END) begin
            phase_nxt = PH_TXID;
          end
        end
        PH_TXID: begin
          if (s1_byte_r == mgcpcc_pkg::CHAR_NUL) begin
            phase_nxt = PH_FAIL;
          end else if (s1_byte_r == mgcpcc_pkg::CHAR_SPACE) begin
            ep_start_nxt = pos_r + 1'b1;
            phase_nxt    = PH_ENDPOINT;
          end
        end
        PH_ENDPOINT: begin
          if (s1_byte_r == mgcpcc_pkg::CHAR_NUL) begin
            phase_nxt = PH_FAIL;
          end else if (s1_byte_r == mgcpcc_pkg::CHAR_AT) begin
            if (!at_seen_r) begin
              at_seen_nxt = 1'b1;
              at_pos_nxt  = pos_r;
            end
          end else if (s1_byte_r == mgcpcc_pkg::CHAR_SPACE) begin
            ep_end_nxt = pos_r;
            mcnt_nxt   = '0;
            phase_nxt  = PH_MARKER;
          end
        end
        PH_MARKER: begin
          if (mgcpcc_pkg::MARKER_TEXT[mcnt_r] != s1_byte_r) begin
            phase_nxt = PH_FAIL;
          end else begin
            mcnt_nxt = mcnt_r + 1'b1;
            if (mcnt_r == MARKER_LAST) begin
              phase_nxt = PH_TAIL;
            end
          end
        end
        PH_TAIL: begin
          phase_nxt = PH_TAIL;
        end
        default: begin
          phase_nxt = PH_FAIL;
        end
      endcase
    end
  end

  // Judge the payload on its final byte and locate the hostname
  assign hit = (phase_nxt == PH_TAIL) && (s1_byte_r == mgcpcc_pkg::CHAR_LF) &&
               (pos_r >= POS_MIN_LAST);
  assign off = at_seen_nxt ? (at_pos_nxt + 1'b1) : ep_start_nxt;
  assign len = ep_end_nxt - off;

  assign res_valid       = fire && s1_last_r;
  assign res.is_mgcp     = hit;
  assign res.host_offset = hit ? 16'(off) : 16'd0;
  assign res.host_length = hit ? 16'(len) : 16'd0;

  // Hold parser state; return to the start state after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && s1_last_r)) begin
      pos_r      <= '0;
      phase_r    <= PH_VERB;
      cand_r     <= '1;
      ep_start_r <= '0;
      at_pos_r   <= '0;
      at_seen_r  <= 1'b0;
      mcnt_r     <= '0;
      ep_end_r   <= '0;
    end else if (fire) begin
      pos_r      <= pos_nxt;
      phase_r    <= phase_nxt;
      cand_r     <= cand_nxt;
      ep_start_r <= ep_start_nxt;
      at_pos_r   <= at_pos_nxt;
      at_seen_r  <= at_seen_nxt;
      mcnt_r     <= mcnt_nxt;
      ep_end_r   <= ep_end_nxt;
    end
  end

`ifndef SYNTHESIS
  a_hold_keeps_word: assert property (@(posedge clk) disable iff (!rst_n)
    hold |=> s1_valid_r && s1_last_r && $stable(s1_byte_r))
    else $error("held final word was lost or changed");

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> pos_r == '0 && phase_r == PH_VERB && cand_r == '1)
    else $error("parser did not restart after final byte");

  a_verb_phase_early: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_VERB |-> pos_r <= POS_VERB_END)
    else $error("verb phase past the verb length");

  a_marker_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_MARKER |-> mcnt_r <= MARKER_LAST)
    else $error("marker count out of range");
`endif

endmodule

/* rtl/core/mgcpcc_out_reg.sv */
// Result register that parts the parser from the result channel.
module mgcpcc_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  mgcpcc_pkg::result_t res,
  output logic                res_stall,
  output logic                out_valid,
  output logic                out_is_mgcp,
  output logic [15:0]         out_host_offset,
  output logic [15:0]         out_host_length,
  input  logic                out_stall
);

  logic                out_valid_r, out_valid_nxt;
  mgcpcc_pkg::result_t data_r;

  // Block new results only while a stored word is being stalled
  assign res_stall = out_valid_r && out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (!res_stall) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load payload when a result is offered and the slot is free
  always_ff @(posedge clk) begin
    if (!res_stall && res_valid) begin
      data_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_mgcp     = data_r.is_mgcp;
  assign out_host_offset = data_r.host_offset;
  assign out_host_length = data_r.host_length;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_stall |-> !res_valid)
    else $error("result offered while the slot is stalled");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !data_r.is_mgcp |-> data_r.host_offset == 16'd0 &&
                                        data_r.host_length == 16'd0)
    else $error("non-command result carries hostname fields");

  a_stalled_stays: assert property (@(posedge clk) disable iff (!rst_n)
    res_stall |=> out_valid_r)
    else $error("stalled result dropped");
`endif

endmodule

/* rtl/core/mgcp_command_classifier.sv */
// Top level of the MGCP command classifier.
//
// Usage: feed a UDP payload one byte per word on the in_ channel, with
// in_end_of_payload high on the final byte. One result word comes out on
// the out_ channel for each payload, after its final byte, and none for the
// other bytes. out_is_mgcp tells whether the payload is an MGCP command;
// out_host_offset and out_host_length locate the hostname and are zero
// otherwise.
// Path: a final byte passes the input register, then the result register,
// before its result word shows on out_valid.
// Throughput: one byte per cycle while no final byte is held, since the parser
// step between the input register and the result register is combinational.
// Stall: while the result register holds a stalled word, bytes that are
// not final keep flowing; a final byte waits in the input register and
// in_stall rises until the result register frees.
// Reset: synchronous, active low; clears both registers' valid flags and
// returns the parser to the start of a payload.
module mgcp_command_classifier #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_payload_byte,
  input  logic        in_end_of_payload,
  output logic        in_stall,
  output logic        out_valid,
  output logic        out_is_mgcp,
  output logic [15:0] out_host_offset,
  output logic [15:0] out_host_length,
  input  logic        out_stall
);

  logic                res_valid;
  logic                res_stall;
  mgcpcc_pkg::result_t res;

  // Parse bytes
  mgcpcc_parser #(
    .POSITION_BITS (POSITION_BITS)
  ) u_parser (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_payload_byte   (in_payload_byte),
    .in_end_of_payload (in_end_of_payload),
    .in_stall          (in_stall),
    .res_stall         (res_stall),
    .res_valid         (res_valid),
    .res               (res)
  );

  // Register results
  mgcpcc_out_reg u_out_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res_valid),
    .res             (res),
    .res_stall       (res_stall),
    .out_valid       (out_valid),
    .out_is_mgcp     (out_is_mgcp),
    .out_host_offset (out_host_offset),
    .out_host_length (out_host_length),
    .out_stall       (out_stall)
  );

endmodule
